// ===== hdl/cbgir_pkg.sv =====
// ----------------------------------------------------------------------------
// cbgir_pkg: shared definitions for the card buffer GPIO register block
// Register offsets, bit masks, item and error codes, and the pin and
// edge-latch helpers that the register logic uses.
// ----------------------------------------------------------------------------
package cbgir_pkg;

  localparam int unsigned PinW = 13;
  localparam int unsigned AuxW = 11;
  localparam int unsigned DataW = 16;

  // Item kinds.
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_IRQ    = 2'd2,
    OP_DETECT = 2'd3
  } op_e;

  // Result error codes.
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_OFFSET   = 3'd1,
    ERR_BITS     = 3'd2,
    ERR_INPUT    = 3'd3,
    ERR_SETTING  = 3'd4
  } err_e;

  // Register byte offsets.
  localparam logic [5:0] OFS_PIN_OUT     = 6'h00;
  localparam logic [5:0] OFS_AUX_OUT     = 6'h02;
  localparam logic [5:0] OFS_PIN_DIR     = 6'h04;
  localparam logic [5:0] OFS_AUX_DIR     = 6'h06;
  localparam logic [5:0] OFS_AUX_SELECT  = 6'h0A;
  localparam logic [5:0] OFS_PIN_VALUE   = 6'h0C;
  localparam logic [5:0] OFS_AUX_VALUE   = 6'h0E;
  localparam logic [5:0] OFS_RISE_EN     = 6'h10;
  localparam logic [5:0] OFS_AUX_RISE_EN = 6'h12;
  localparam logic [5:0] OFS_FALL_EN     = 6'h14;
  localparam logic [5:0] OFS_AUX_FALL_EN = 6'h16;
  localparam logic [5:0] OFS_RISE_STAT   = 6'h18;
  localparam logic [5:0] OFS_AUX_RISE_ST = 6'h1A;
  localparam logic [5:0] OFS_FALL_STAT   = 6'h1C;
  localparam logic [5:0] OFS_AUX_FALL_ST = 6'h1E;
  localparam logic [5:0] OFS_CONTROL     = 6'h20;

  // Bit masks.
  localparam logic [PinW-1:0]  PIN_MASK     = 13'h1FFF;
  localparam logic [DataW-1:0] AUX_MASK     = 16'h07FF;
  localparam logic [DataW-1:0] AUX_VGA      = 16'h0800;
  localparam logic [PinW-1:0]  PIN_DET_MASK = 13'h0C00;
  localparam logic [PinW-1:0]  PIN_VCC_MASK = 13'h00C0;
  localparam logic [PinW-1:0]  PIN_VPP_HIGH = 13'h0020;
  localparam logic [PinW-1:0]  PIN_WP       = 13'h0008;
  localparam logic [PinW-1:0]  PIN_RDY      = 13'h0004;
  localparam logic [PinW-1:0]  PIN_RST      = 13'h0001;
  localparam logic [DataW-1:0] PIN_OUT_OK   = 16'h10F1;
  localparam logic [DataW-1:0] PIN_FULL     = 16'h1FFF;
  localparam logic [DataW-1:0] CTL_KNOWN    = 16'h801F;
  localparam logic [DataW-1:0] CTL_ADDR     = 16'h0010;
  localparam logic [DataW-1:0] CTL_CARD_EN  = 16'h0004;
  localparam logic [DataW-1:0] CTL_GLOBAL   = 16'h0002;
  localparam logic [DataW-1:0] CTL_SOFT_RST = 16'h0040;

  // Architectural register state.
  typedef struct packed {
    logic [PinW-1:0]  pin_out;
    logic [PinW-1:0]  pin_dir;
    logic [PinW-1:0]  rise_enable;
    logic [PinW-1:0]  fall_enable;
    logic [PinW-1:0]  rise_status;
    logic [PinW-1:0]  fall_status;
    logic [AuxW-1:0]  aux_out;
    logic [AuxW-1:0]  aux_dir;
    logic [AuxW-1:0]  aux_select;
    logic [DataW-1:0] control;
    logic [PinW-1:0]  last_pin_value;
    logic             reset_driven;
    logic             card_irq_held;
    logic             card_powered;
  } regs_t;

  // Sensed pin value: outputs where driven, pull-ups elsewhere, then card
  // detect when a card is present, write-protect and ready if it is powered.
  function automatic logic [PinW-1:0] pin_value(regs_t s, logic present);
    logic [PinW-1:0] v;
    v = (s.pin_out & s.pin_dir) | (PIN_MASK & ~s.pin_dir);
    if (present) begin
      v = v & ~PIN_DET_MASK;
      if (s.card_powered) begin
        v = v & ~PIN_WP;
        if (s.card_irq_held) begin
          v = v & ~PIN_RDY;
        end else begin
          v = v | PIN_RDY;
        end
      end
    end
    return v;
  endfunction

  // Compare the pin value with the last one and latch rising and falling edges.
  function automatic regs_t latch_edges(regs_t s, logic present);
    logic [PinW-1:0] now;
    logic [PinW-1:0] diff;
    now = pin_value(s, present);
    diff = now ^ s.last_pin_value;
    s.rise_status = s.rise_status | (diff & now);
    s.fall_status = s.fall_status | (diff & ~now);
    s.last_pin_value = now;
    return s;
  endfunction

  // Drive card reset and power from the pins, latching edges before and
  // after the power change.
  function automatic regs_t apply_outputs(regs_t s, logic present);
    logic [PinW-1:0] d;
    d = s.pin_out & s.pin_dir;
    s.reset_driven = |(d & PIN_RST);
    s = latch_edges(s, present);
    s.card_powered = |(d & PIN_VCC_MASK);
    s = latch_edges(s, present);
    return s;
  endfunction

  // True when the driven outputs would select high Vpp or both Vcc rails.
  function automatic logic drive_bad(logic [PinW-1:0] o, logic [PinW-1:0] dir);
    logic [PinW-1:0] d;
    d = o & dir;
    return (|(d & PIN_VPP_HIGH)) || ((d & PIN_VCC_MASK) == PIN_VCC_MASK);
  endfunction

endpackage

// ===== hdl/card_buffer_gpio_interrupt_regs.sv =====
// ----------------------------------------------------------------------------
// card_buffer_gpio_interrupt_regs: PC Card buffer GPIO register file
// Register reads and writes, card interrupt and card detect events, edge
// status latching and the interrupt, power and reset-release outputs.
// ----------------------------------------------------------------------------
// Requests pass the input register, then the result register at the outputs.
// One request per cycle unless the output stalls; the register update is one
// pass of bit logic between the input register and the result register.
// Reset: rst_ni clears the register state, edge status and the pipeline valids.
module card_buffer_gpio_interrupt_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  reg_offset_i,
  input  logic [15:0] write_value_i,
  input  logic        card_present_i,
  input  logic        card_irq_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        int_level_o,
  output logic        card_power_o,
  output logic        card_reset_release_o,
  output logic        card_enable_o,
  output logic [2:0]  error_code_o
);

  typedef struct packed {
    logic [15:0]      read_data;
    logic             int_level;
    logic             card_power;
    logic             release_pulse;
    logic             card_enable;
    cbgir_pkg::err_e  err;
  } result_t;

  logic               in_valid_q;
  logic [1:0]         op_q;
  logic [5:0]         ofs_q;
  logic [15:0]        val_q;
  logic               present_q;
  logic               irq_q;
  logic               out_valid_q;
  logic               advance;
  cbgir_pkg::regs_t   st_q, st_d;
  result_t            res_q, res_d;

  // The input stage moves on whenever the result register is free or drains.
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q      <= operation_i;
      ofs_q     <= reg_offset_i;
      val_q     <= write_value_i;
      present_q <= card_present_i;
      irq_q     <= card_irq_level_i;
    end
  end

  // Register update and result for the request in the input register.
  always_comb begin
    cbgir_pkg::regs_t nx;
    logic [15:0]      rd;
    cbgir_pkg::err_e  err;
    logic             rel;
    logic [12:0]      new_out;
    logic [12:0]      new_dir;
    nx      = st_q;
    rd      = '0;
    err     = cbgir_pkg::ERR_OK;
    rel     = 1'b0;
    new_out = (ofs_q == cbgir_pkg::OFS_PIN_OUT) ? val_q[12:0] : st_q.pin_out;
    new_dir = (ofs_q == cbgir_pkg::OFS_PIN_DIR) ? val_q[12:0] : st_q.pin_dir;
    case (op_q)
      cbgir_pkg::OP_IRQ: begin
        nx.card_irq_held = irq_q;
        nx = cbgir_pkg::latch_edges(nx, present_q);
      end
      cbgir_pkg::OP_DETECT: begin
        nx = cbgir_pkg::latch_edges(nx, present_q);
      end
      default: begin
        if (ofs_q[0] || (ofs_q > cbgir_pkg::OFS_CONTROL)) begin
          err = cbgir_pkg::ERR_OFFSET;
        end else if (op_q == cbgir_pkg::OP_READ) begin
          // Register reads; the pin value and status reads latch edges first.
          case (ofs_q)
            cbgir_pkg::OFS_PIN_OUT:    rd = {3'b0, st_q.pin_out};
            cbgir_pkg::OFS_AUX_OUT:    rd = {5'b0, st_q.aux_out};
            cbgir_pkg::OFS_PIN_DIR:    rd = {3'b0, st_q.pin_dir};
            cbgir_pkg::OFS_AUX_DIR:    rd = {5'b0, st_q.aux_dir};
            cbgir_pkg::OFS_AUX_SELECT: rd = {5'b0, st_q.aux_select};
            cbgir_pkg::OFS_PIN_VALUE: begin
              nx = cbgir_pkg::latch_edges(nx, present_q);
              rd = {3'b0, nx.last_pin_value};
            end
            cbgir_pkg::OFS_AUX_VALUE:  rd = {5'b0, st_q.aux_out & st_q.aux_dir};
            cbgir_pkg::OFS_RISE_EN:    rd = {3'b0, st_q.rise_enable};
            cbgir_pkg::OFS_FALL_EN:    rd = {3'b0, st_q.fall_enable};
            cbgir_pkg::OFS_RISE_STAT: begin
              nx = cbgir_pkg::latch_edges(nx, present_q);
              rd = {3'b0, nx.rise_status};
            end
            cbgir_pkg::OFS_FALL_STAT: begin
              nx = cbgir_pkg::latch_edges(nx, present_q);
              rd = {3'b0, nx.fall_status};
            end
            cbgir_pkg::OFS_CONTROL:    rd = st_q.control;
            default:                   rd = '0;
          endcase
        end else begin
          // Register writes with their reserved-bit and setting checks.
          case (ofs_q)
            cbgir_pkg::OFS_PIN_OUT, cbgir_pkg::OFS_PIN_DIR: begin
              if ((val_q & ~cbgir_pkg::PIN_OUT_OK) != '0) begin
                err = cbgir_pkg::ERR_BITS;
              end else if (cbgir_pkg::drive_bad(new_out, new_dir)) begin
                err = cbgir_pkg::ERR_SETTING;
              end else begin
                nx.pin_out = new_out;
                nx.pin_dir = new_dir;
                rel = st_q.reset_driven && !(new_out[0] && new_dir[0]);
                nx = cbgir_pkg::apply_outputs(nx, present_q);
              end
            end
            cbgir_pkg::OFS_AUX_OUT, cbgir_pkg::OFS_AUX_DIR: begin
              if ((val_q & ~cbgir_pkg::AUX_MASK) != '0) begin
                err = cbgir_pkg::ERR_BITS;
              end else if (ofs_q == cbgir_pkg::OFS_AUX_OUT) begin
                nx.aux_out = val_q[10:0];
              end else begin
                nx.aux_dir = val_q[10:0];
              end
            end
            cbgir_pkg::OFS_AUX_SELECT: begin
              if ((val_q & ~(cbgir_pkg::AUX_MASK | cbgir_pkg::AUX_VGA)) != '0) begin
                err = cbgir_pkg::ERR_BITS;
              end else if ((val_q & cbgir_pkg::AUX_VGA) != '0) begin
                err = cbgir_pkg::ERR_SETTING;
              end else begin
                nx.aux_select = val_q[10:0];
              end
            end
            cbgir_pkg::OFS_PIN_VALUE, cbgir_pkg::OFS_AUX_VALUE: begin
              err = cbgir_pkg::ERR_INPUT;
            end
            cbgir_pkg::OFS_RISE_EN, cbgir_pkg::OFS_FALL_EN: begin
              if ((val_q & ~cbgir_pkg::PIN_FULL) != '0) begin
                err = cbgir_pkg::ERR_BITS;
              end else if (ofs_q == cbgir_pkg::OFS_RISE_EN) begin
                nx.rise_enable = val_q[12:0];
              end else begin
                nx.fall_enable = val_q[12:0];
              end
            end
            cbgir_pkg::OFS_AUX_RISE_EN, cbgir_pkg::OFS_AUX_FALL_EN: begin
              if (val_q != '0) begin
                err = cbgir_pkg::ERR_BITS;
              end
            end
            cbgir_pkg::OFS_RISE_STAT: nx.rise_status = st_q.rise_status & ~val_q[12:0];
            cbgir_pkg::OFS_FALL_STAT: nx.fall_status = st_q.fall_status & ~val_q[12:0];
            cbgir_pkg::OFS_AUX_RISE_ST, cbgir_pkg::OFS_AUX_FALL_ST: begin
              nx = st_q;
            end
            cbgir_pkg::OFS_CONTROL: begin
              if ((val_q & cbgir_pkg::CTL_SOFT_RST) != '0) begin
                if (val_q != cbgir_pkg::CTL_SOFT_RST) begin
                  err = cbgir_pkg::ERR_BITS;
                end else begin
                  // Soft reset clears the register file, then re-drives the pins.
                  nx.pin_out     = '0;
                  nx.pin_dir     = '0;
                  nx.rise_enable = '0;
                  nx.fall_enable = '0;
                  nx.rise_status = '0;
                  nx.fall_status = '0;
                  nx.aux_out     = '0;
                  nx.aux_dir     = '0;
                  nx.aux_select  = '0;
                  nx.control     = '0;
                  rel = st_q.reset_driven;
                  nx = cbgir_pkg::apply_outputs(nx, present_q);
                end
              end else if ((val_q & ~cbgir_pkg::CTL_KNOWN) != '0) begin
                err = cbgir_pkg::ERR_BITS;
              end else if ((val_q & cbgir_pkg::CTL_ADDR) != '0) begin
                err = cbgir_pkg::ERR_SETTING;
              end else begin
                nx.control = val_q;
              end
            end
            default: err = cbgir_pkg::ERR_OFFSET;
          endcase
        end
      end
    endcase

    st_d = nx;
    res_d.read_data     = rd;
    res_d.int_level     = ((nx.control & cbgir_pkg::CTL_GLOBAL) != '0) &&
                          (|((nx.rise_status & nx.rise_enable) |
                             (nx.fall_status & nx.fall_enable)));
    res_d.card_power    = nx.card_powered;
    res_d.release_pulse = rel;
    res_d.card_enable   = (nx.control & cbgir_pkg::CTL_CARD_EN) != '0;
    res_d.err           = err;
  end

  // Register state commits when the request moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign read_data_o          = res_q.read_data;
  assign int_level_o          = res_q.int_level;
  assign card_power_o         = res_q.card_power;
  assign card_reset_release_o = res_q.release_pulse;
  assign card_enable_o        = res_q.card_enable;
  assign error_code_o         = res_q.err;

`ifndef SYNTH
  // A failed request returns no read data.
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o != cbgir_pkg::ERR_OK)) |-> (read_data_o == '0))
    else $error("error result carries read data");

  // A reset-release pulse only comes from an accepted write.
  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && card_reset_release_o) |-> (error_code_o == cbgir_pkg::ERR_OK))
    else $error("reset release on a failed request");

  // The input side only stalls while the input register holds a request.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked request");
`endif

endmodule
